// File: hw/rtl/tmrs_pkg.sv
package tmrs_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int MAX_LEN_DEF = 32;
    localparam int BLOCK_ENTRIES_DEF = 4;
    localparam int SWEEP_DIVISOR_DEF = 8;
    localparam logic [5:0] LAST_SECOND = 6'd59;

    localparam logic [1:0] OP_PUBLISH = 2'd0;
    localparam logic [1:0] OP_SUBSCRIBE = 2'd1;
    localparam logic [1:0] OP_SERVICE = 2'd2;
    localparam logic [1:0] OP_SECOND = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_NO_MATCH = 2'd3;

    localparam logic [1:0] REG_BLOCKED_HEADERS = 2'd0;
    localparam logic [1:0] REG_BLOCKED_COUNT = 2'd1;
    localparam logic [1:0] REG_EXPIRY = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] topic;
        logic [7:0] msg_length;
        logic [7:0] payload_byte;
        logic       final_byte;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_byte;
        logic       end_of_run;
    } result_t;

    // classified command from front to back
    typedef struct packed {
        cmd_t       cmd;
        logic       blocked;
        logic       too_long;
    } task_t;

endpackage

// File: hw/rtl/tmrs_front.sv
module tmrs_front
    import tmrs_pkg::*;
#(
    parameter int BLOCK_ENTRIES = BLOCK_ENTRIES_DEF,
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        cmd,
    input  logic [31:0] blocked_headers,
    input  logic [2:0]  blocked_count,
    input  logic        q_full,
    output logic        accept,
    output logic        push,
    output task_t       push_task
);

    logic blk;

    always_comb
    begin
        blk = 1'b0;
        for (int i = 0; i < BLOCK_ENTRIES; i++)
        begin
            if ((32'(i) < 32'(blocked_count)) && (blocked_headers[8*i +: 8] == cmd.topic))
            begin
                blk = 1'b1;
            end
        end
    end

    assign accept = start && !q_full;
    assign push = accept;
    assign push_task.cmd = cmd;
    assign push_task.blocked = blk;
    assign push_task.too_long = (cmd.msg_length > 8'(MAX_LEN));

endmodule

// File: hw/rtl/tmrs_queue.sv
module tmrs_queue
    import tmrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  task_t push_task,
    input  logic  pop,
    output logic  full,
    output logic  valid,
    output task_t head
);

    task_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic rd_reg;
    logic wr_reg;

    assign full = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign head = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_task;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !valid |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");

endmodule

// File: hw/rtl/tmrs_back.sv
module tmrs_back
    import tmrs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int SWEEP_DIVISOR = SWEEP_DIVISOR_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    input  task_t      head,
    input  logic [5:0] expiry_seconds,
    output logic       pop,
    output logic       done,
    output result_t    result
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OW = $clog2(MAX_LEN + 1);
    localparam int BW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int AW = SW + BW;
    localparam int SWEEP_N = SLOTS / SWEEP_DIVISOR;
    localparam int CW = $clog2(SLOTS + 2);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_READ   = 7'b0000100,
        S_SWEEP  = 7'b0001000,
        S_WAIT   = 7'b0010000,
        S_SEND   = 7'b0100000,
        S_CLEAR  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [7:0] hdr_reg [SLOTS];
    logic [5:0] stamp_reg [SLOTS];
    logic [7:0] bytes_mem [SLOTS * MAX_LEN];
    logic [SW-1:0] wslot_reg, slot_reg;
    logic [5:0] now_reg;
    logic [OW-1:0] poff_reg;
    logic [1:0] refused_reg;
    logic [CW-1:0] cnt_reg;
    logic [7:0] idx_reg;
    logic [AW-1:0] clr_reg;
    task_t cur_reg;
    logic [7:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic [SW-1:0] prev_s, next_w;
    logic [5:0] diff;
    result_t res_reg;
    logic done_reg;

    function automatic logic [SW-1:0] prevs(input logic [SW-1:0] s);
        return (s == '0) ? SW'(SLOTS - 1) : s - SW'(1);
    endfunction

    function automatic logic [SW-1:0] nexts(input logic [SW-1:0] s);
        return (32'(s) + 1 >= SLOTS) ? '0 : s + SW'(1);
    endfunction

    assign prev_s = prevs(slot_reg);
    assign next_w = nexts(wslot_reg);
    assign diff = (stamp_reg[slot_reg] > now_reg) ? stamp_reg[slot_reg] - now_reg
                                                  : now_reg - stamp_reg[slot_reg];
    assign pop = valid && (state_reg == S_IDLE);
    assign raddr = AW'(32'(slot_reg) * MAX_LEN + 32'(idx_reg[BW-1:0]));
    assign done = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk)
    begin
        rdata_reg <= bytes_mem[raddr];
        if (state_reg == S_CLEAR)
        begin
            bytes_mem[clr_reg] <= 8'd0;
        end
        else if (pop && head.cmd.op == OP_PUBLISH && refused_reg == ST_OK && !head.too_long
            && !head.blocked && 32'(poff_reg) < MAX_LEN)
        begin
            bytes_mem[AW'(32'(wslot_reg) * MAX_LEN + 32'(poff_reg))] <= head.cmd.payload_byte;
        end
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            for (int i = 0; i < SLOTS; i++)
            begin
                hdr_reg[i] <= '0;
                stamp_reg[i] <= '0;
            end
            wslot_reg <= '0;
            slot_reg <= '0;
            now_reg <= '0;
            poff_reg <= '0;
            refused_reg <= ST_OK;
            cnt_reg <= '0;
            idx_reg <= '0;
            clr_reg <= '0;
            res_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(SLOTS * MAX_LEN - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pop)
                    begin
                        case (head.cmd.op)
                            OP_PUBLISH:
                            begin
                                logic [1:0] r;
                                logic adv;
                                r = refused_reg;
                                adv = 1'b0;
                                if (r == ST_OK)
                                begin
                                    if (head.too_long) r = ST_TOO_LONG;
                                    else if (head.blocked) r = ST_BLOCKED;
                                    else if (32'(poff_reg) >= MAX_LEN) r = ST_TOO_LONG;
                                    else adv = 1'b1;
                                end
                                res_reg <= '{status: r, read_byte: 8'd0, end_of_run: 1'b1};
                                done_reg <= 1'b1;
                                if (head.cmd.final_byte)
                                begin
                                    if (r == ST_OK)
                                    begin
                                        hdr_reg[wslot_reg] <= head.cmd.topic;
                                        stamp_reg[wslot_reg] <= now_reg;
                                        wslot_reg <= next_w;
                                    end
                                    poff_reg <= '0;
                                    refused_reg <= ST_OK;
                                end
                                else
                                begin
                                    refused_reg <= r;
                                    if (adv)
                                    begin
                                        poff_reg <= poff_reg + OW'(1);
                                    end
                                end
                            end
                            OP_SUBSCRIBE:
                            begin
                                if (head.too_long || head.blocked)
                                begin
                                    res_reg <= '{status: head.too_long ? ST_TOO_LONG : ST_BLOCKED,
                                                 read_byte: 8'd0, end_of_run: 1'b1};
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    slot_reg <= wslot_reg;
                                    cnt_reg <= '0;
                                    state_reg <= S_SEARCH;
                                end
                            end
                            OP_SERVICE:
                            begin
                                wslot_reg <= next_w;
                                slot_reg <= next_w;
                                cnt_reg <= '0;
                                if (SWEEP_N == 0)
                                begin
                                    res_reg <= '{status: ST_OK, read_byte: 8'd0, end_of_run: 1'b1};
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_SWEEP;
                                end
                            end
                            default:
                            begin
                                now_reg <= (now_reg >= LAST_SECOND) ? 6'd0 : now_reg + 6'd1;
                                res_reg <= '{status: ST_OK, read_byte: 8'd0, end_of_run: 1'b1};
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    if (hdr_reg[slot_reg] == cur_reg.cmd.topic)
                    begin
                        if (cur_reg.cmd.msg_length == 8'd0)
                        begin
                            res_reg <= '{status: ST_OK, read_byte: 8'd0, end_of_run: 1'b1};
                            done_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= '0;
                            state_reg <= S_WAIT;
                        end
                    end
                    else if (32'(cnt_reg) + 1 >= SLOTS)
                    begin
                        res_reg <= '{status: ST_NO_MATCH, read_byte: 8'd0, end_of_run: 1'b1};
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        slot_reg <= prev_s;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_SEND;
                end
                S_SEND:
                begin
                    res_reg <= '{status: ST_OK, read_byte: rdata_reg,
                                 end_of_run: (idx_reg + 8'd1 == cur_reg.cmd.msg_length)};
                    done_reg <= 1'b1;
                    if (idx_reg + 8'd1 == cur_reg.cmd.msg_length)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 8'd1;
                        state_reg <= S_WAIT;
                    end
                end
                S_SWEEP:
                begin
                    if (diff > expiry_seconds)
                    begin
                        hdr_reg[slot_reg] <= '0;
                        stamp_reg[slot_reg] <= now_reg;
                    end
                    slot_reg <= prev_s;
                    if (32'(cnt_reg) + 1 >= SWEEP_N)
                    begin
                        res_reg <= '{status: ST_OK, read_byte: 8'd0, end_of_run: 1'b1};
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEND) |=> done_reg)
        else $error("read byte not delivered");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.cmd.op == OP_SECOND) |=> done_reg && res_reg.status == ST_OK)
        else $error("second tick result missing");
    assert property (@(posedge clk) disable iff (!rst_n) 32'(poff_reg) <= MAX_LEN)
        else $error("publish offset overrun");

endmodule

// File: hw/rtl/topic_message_ring_store.sv
// publish and second ticks: the command is queued, then popped in S_IDLE and its result registered
// subscribe: searches back from the write slot over up to SLOTS slots, then streams each byte via S_WAIT, S_SEND
// service tick: advances the write slot, then sweeps SLOTS / SWEEP_DIVISOR slots, one slot swept per cycle
// throughput: publish and second ticks one per cycle while busy is low, else one command at a time
// reset clears slot table and pointers, then S_CLEAR zeroes all SLOTS * MAX_LEN message bytes
// results are single-cycle strobes; the receiver cannot stall
module topic_message_ring_store
    import tmrs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int BLOCK_ENTRIES = BLOCK_ENTRIES_DEF,
    parameter int SWEEP_DIVISOR = SWEEP_DIVISOR_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        strobe,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] blocked_headers_reg;
    logic [2:0] blocked_count_reg;
    logic [5:0] expiry_reg;
    logic q_full, q_valid, accept, push, pop;
    task_t push_task, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocked_headers_reg <= '0;
            blocked_count_reg <= '0;
            expiry_reg <= 6'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCKED_HEADERS: blocked_headers_reg <= cfg_data;
                REG_BLOCKED_COUNT: blocked_count_reg <= cfg_data[2:0];
                REG_EXPIRY: expiry_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign busy = q_full;

    tmrs_front #(.BLOCK_ENTRIES(BLOCK_ENTRIES), .MAX_LEN(MAX_LEN)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .blocked_headers(blocked_headers_reg), .blocked_count(blocked_count_reg),
        .q_full(q_full), .accept(accept), .push(push), .push_task(push_task)
    );

    tmrs_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_task(push_task), .pop(pop),
        .full(q_full), .valid(q_valid), .head(head)
    );

    tmrs_back #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN), .SWEEP_DIVISOR(SWEEP_DIVISOR)) u_back (
        .clk(clk), .rst_n(rst_n), .valid(q_valid), .head(head),
        .expiry_seconds(expiry_reg), .pop(pop), .done(strobe), .result(result)
    );

endmodule

// File: tb/sv/tb_topic_message_ring_store.sv
`timescale 1ns / 1ps

module tb_topic_message_ring_store;
    import tmrs_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam int MAX_LEN = MAX_LEN_DEF;
    localparam int SWEEP_COUNT = SLOTS_DEF / SWEEP_DIVISOR_DEF;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        strobe;
    result_t     result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    topic_message_ring_store dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .strobe(strobe), .result(result), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // store state mirror
    logic [7:0]  store_bytes [SLOTS*MAX_LEN];
    logic [7:0]  store_headers [SLOTS];
    logic [5:0]  store_stamps [SLOTS];
    int          wr_slot;
    int          seconds_now;
    int          pub_offset;
    logic [1:0]  pub_refused;
    logic [31:0] blk_headers;
    logic [2:0]  blk_count;
    logic [5:0]  expiry;

    result_t pending_results [$];
    int      errors;
    int      sender_idle;

    typedef struct {
        cmd_t    c;
        logic    known;
        result_t r;
    } row_t;
    row_t rows [$];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic is_blocked(logic [7:0] t);
        int n;
        logic hit;
        n = (blk_count > 4) ? 4 : blk_count;
        hit = 1'b0;
        for (int i = 0; i < n; i++)
            if (blk_headers[8*i +: 8] == t)
                hit = 1'b1;
        return hit;
    endfunction

    function automatic result_t mk(logic [1:0] st, logic [7:0] b, logic e);
        result_t r;
        r.status = st;
        r.read_byte = b;
        r.end_of_run = e;
        return r;
    endfunction

    task automatic predict_store(input cmd_t c);
        int s;
        int st;
        int diff;
        logic found;
        case (c.op)
            OP_PUBLISH:
            begin
                if (pub_refused == ST_OK)
                begin
                    if (c.msg_length > MAX_LEN)
                        pub_refused = ST_TOO_LONG;
                    else if (is_blocked(c.topic))
                        pub_refused = ST_BLOCKED;
                    else if (pub_offset >= MAX_LEN)
                        pub_refused = ST_TOO_LONG;
                    else
                    begin
                        store_bytes[wr_slot*MAX_LEN + pub_offset] = c.payload_byte;
                        pub_offset++;
                    end
                end
                pending_results.push_back(mk(pub_refused, 8'd0, 1'b1));
                if (c.final_byte)
                begin
                    if (pub_refused == ST_OK)
                    begin
                        store_headers[wr_slot] = c.topic;
                        store_stamps[wr_slot] = 6'(seconds_now);
                        wr_slot = (wr_slot + 1) % SLOTS;
                    end
                    pub_offset = 0;
                    pub_refused = ST_OK;
                end
            end
            OP_SUBSCRIBE:
            begin
                if (c.msg_length > MAX_LEN)
                    pending_results.push_back(mk(ST_TOO_LONG, 8'd0, 1'b1));
                else if (is_blocked(c.topic))
                    pending_results.push_back(mk(ST_BLOCKED, 8'd0, 1'b1));
                else
                begin
                    s = wr_slot;
                    found = 1'b0;
                    for (int i = 0; i < SLOTS && !found; i++)
                    begin
                        if (store_headers[s] == c.topic)
                            found = 1'b1;
                        else
                            s = (s == 0) ? SLOTS - 1 : s - 1;
                    end
                    if (!found)
                        pending_results.push_back(mk(ST_NO_MATCH, 8'd0, 1'b1));
                    else if (c.msg_length == 0)
                        pending_results.push_back(mk(ST_OK, 8'd0, 1'b1));
                    else
                        for (int i = 0; i < c.msg_length; i++)
                            pending_results.push_back(mk(ST_OK, store_bytes[s*MAX_LEN + i],
                                                         i + 1 == c.msg_length));
                end
            end
            OP_SERVICE:
            begin
                wr_slot = (wr_slot + 1) % SLOTS;
                s = wr_slot;
                for (int i = 0; i < SWEEP_COUNT; i++)
                begin
                    st = store_stamps[s];
                    diff = (st > seconds_now) ? st - seconds_now : seconds_now - st;
                    if (diff > expiry)
                    begin
                        store_headers[s] = 8'd0;
                        store_stamps[s] = 6'(seconds_now);
                    end
                    s = (s == 0) ? SLOTS - 1 : s - 1;
                end
                pending_results.push_back(mk(ST_OK, 8'd0, 1'b1));
            end
            default:
            begin
                seconds_now = (seconds_now >= LAST_SECOND) ? 0 : seconds_now + 1;
                pending_results.push_back(mk(ST_OK, 8'd0, 1'b1));
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected transaction: actual %h", $time, result);
                errors++;
            end
            else
            begin
                if (result !== pending_results[0])
                begin
                    $display("%0t mismatch: expected %h actual %h", $time,
                             pending_results[0], result);
                    errors++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    task automatic send_cmd(input cmd_t c);
        while ($urandom_range(99) < sender_idle)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_store(c);
    endtask

    task automatic drain_store;
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BLOCKED_HEADERS: blk_headers = val;
            REG_BLOCKED_COUNT: blk_count = val[2:0];
            default: expiry = val[5:0];
        endcase
        @(posedge clk);
    endtask

    function automatic cmd_t mkcmd(logic [1:0] op, logic [7:0] t, logic [7:0] l,
                                   logic [7:0] p, logic f);
        cmd_t c;
        c.op = op;
        c.topic = t;
        c.msg_length = l;
        c.payload_byte = p;
        c.final_byte = f;
        return c;
    endfunction

    function automatic void add_row(cmd_t c, logic k, result_t r);
        row_t x;
        x.c = c;
        x.known = k;
        x.r = r;
        rows.push_back(x);
    endfunction

    function automatic cmd_t rand_cmd(logic [7:0] t, int n, int i);
        cmd_t c;
        c = mkcmd(OP_PUBLISH, t, 8'($urandom_range(MAX_LEN)), 8'($urandom_range(255)),
                  i == n - 1);
        return c;
    endfunction

    task automatic random_phase(input int idle, input int count);
        logic [7:0] t;
        int n;
        int k;
        sender_idle = idle;
        for (int j = 0; j < count; j++)
        begin
            t = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
            k = $urandom_range(99);
            if (k < 35)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN + 3) : $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_cmd(rand_cmd(t, n, i));
            end
            else if (k < 65)
                send_cmd(mkcmd(OP_SUBSCRIBE, t,
                               ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                        : 8'($urandom_range(MAX_LEN)),
                               8'($urandom_range(255)), 1'($urandom_range(1))));
            else if (k < 80)
                send_cmd(mkcmd(OP_SERVICE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 1'($urandom_range(1))));
            else if (k < 95)
                send_cmd(mkcmd(OP_SECOND, 8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 1'($urandom_range(1))));
            else
                send_cmd(mkcmd(OP_PUBLISH, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                               1'($urandom())));
        end
    endtask

    initial
    begin
        errors = 0;
        sender_idle = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = REG_BLOCKED_HEADERS;
        cfg_data = '0;
        for (int i = 0; i < SLOTS*MAX_LEN; i++)
            store_bytes[i] = 8'd0;
        for (int i = 0; i < SLOTS; i++)
        begin
            store_headers[i] = 8'd0;
            store_stamps[i] = 6'd0;
        end
        wr_slot = 0;
        seconds_now = 0;
        pub_offset = 0;
        pub_refused = ST_OK;
        blk_headers = '0;
        blk_count = '0;
        expiry = 6'd10;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_row(mkcmd(OP_SUBSCRIBE, 8'h55, 8'd4, 8'd0, 1'b0), 1'b1,
                mk(ST_NO_MATCH, 8'd0, 1'b1));
        add_row(mkcmd(OP_SUBSCRIBE, 8'h00, 8'd0, 8'd0, 1'b0), 1'b1, mk(ST_OK, 8'd0, 1'b1));
        add_row(mkcmd(OP_SUBSCRIBE, 8'h00, 8'd255, 8'd0, 1'b0), 1'b1,
                mk(ST_TOO_LONG, 8'd0, 1'b1));
        add_row(mkcmd(OP_SUBSCRIBE, 8'h00, 8'd2, 8'd0, 1'b0), 1'b0, mk(ST_OK, 8'd0, 1'b1));
        add_row(mkcmd(OP_PUBLISH, 8'hFF, 8'd2, 8'hFF, 1'b0), 1'b1, mk(ST_OK, 8'd0, 1'b1));
        add_row(mkcmd(OP_PUBLISH, 8'hAA, 8'd2, 8'h00, 1'b1), 1'b1, mk(ST_OK, 8'd0, 1'b1));
        add_row(mkcmd(OP_SUBSCRIBE, 8'hAA, 8'd2, 8'd0, 1'b0), 1'b0, mk(ST_OK, 8'd0, 1'b1));
        add_row(mkcmd(OP_PUBLISH, 8'h11, 8'd33, 8'h5A, 1'b0), 1'b1,
                mk(ST_TOO_LONG, 8'd0, 1'b1));
        add_row(mkcmd(OP_PUBLISH, 8'h11, 8'd1, 8'hA5, 1'b1), 1'b1,
                mk(ST_TOO_LONG, 8'd0, 1'b1));
        for (int i = 0; i < MAX_LEN + 1; i++)
            add_row(mkcmd(OP_PUBLISH, 8'h22, 8'(MAX_LEN), 8'(i), i == MAX_LEN), 1'b0,
                    mk(ST_OK, 8'd0, 1'b1));
        add_row(mkcmd(OP_PUBLISH, 8'h33, 8'd32, 8'h81, 1'b0), 1'b0, mk(ST_OK, 8'd0, 1'b1));
        add_row(mkcmd(OP_SERVICE, 8'd0, 8'd0, 8'd0, 1'b0), 1'b1, mk(ST_OK, 8'd0, 1'b1));
        add_row(mkcmd(OP_PUBLISH, 8'h33, 8'd32, 8'h7E, 1'b1), 1'b1, mk(ST_OK, 8'd0, 1'b1));
        add_row(mkcmd(OP_SUBSCRIBE, 8'h33, 8'd32, 8'd0, 1'b0), 1'b0, mk(ST_OK, 8'd0, 1'b1));
        foreach (rows[i])
        begin
            send_cmd(rows[i].c);
            if (rows[i].known && pending_results[pending_results.size()-1] !== rows[i].r)
            begin
                $display("%0t table row %0d: expected %h predicted %h", $time, i,
                         rows[i].r, pending_results[pending_results.size()-1]);
                errors++;
            end
        end
        drain_store();

        // aging: run seconds past expiry, then sweep
        for (int i = 0; i < 62; i++)
            send_cmd(mkcmd(OP_SECOND, 8'd0, 8'd0, 8'd0, 1'b0));
        for (int i = 0; i < SLOTS; i++)
            send_cmd(mkcmd(OP_SERVICE, 8'd0, 8'd0, 8'd0, 1'b0));
        drain_store();

        write_reg(REG_BLOCKED_HEADERS, 32'h03_02_01_00);
        write_reg(REG_BLOCKED_COUNT, 32'd2);
        write_reg(REG_EXPIRY, 32'd3);
        random_phase(0, 25);
        drain_store();

        write_reg(REG_BLOCKED_COUNT, 32'd7);
        write_reg(REG_EXPIRY, 32'd0);
        random_phase(80, 20);
        drain_store();

        write_reg(REG_BLOCKED_HEADERS, $urandom());
        write_reg(REG_BLOCKED_COUNT, 32'd0);
        write_reg(REG_EXPIRY, 32'd63);
        random_phase(34, 20);
        drain_store();

        write_reg(REG_BLOCKED_HEADERS, 32'hFF_FE_05_04);
        write_reg(REG_BLOCKED_COUNT, 32'd4);
        write_reg(REG_EXPIRY, 32'd59);
        random_phase(0, 20);
        drain_store();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/tmrs_pkg.sv
hw/rtl/tmrs_front.sv
hw/rtl/tmrs_queue.sv
hw/rtl/tmrs_back.sv
hw/rtl/topic_message_ring_store.sv
tb/sv/tb_topic_message_ring_store.sv
